### rtl/pnrls_pkg.sv
// ----------------------------------------------------------------------------
// pnrls_pkg
// shared types, widths and codes of the peak normalised run length slicer
// ----------------------------------------------------------------------------
package pnrls_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int RUN_BITS    = 20;
  localparam int CFG_BITS    = 16;
  localparam int IDX_BITS    = 3;
  localparam int EV_BITS     = 3;
  localparam int PROD_BITS   = CFG_BITS + SAMPLE_BITS;
  localparam int WIN_BITS    = CFG_BITS + 1;
  localparam int PK_CMP_BITS = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
  localparam int LEN_CMP_BITS = (RUN_BITS > CFG_BITS) ? RUN_BITS : CFG_BITS;
  localparam int DIV_CNT_BITS = $clog2(RUN_BITS);
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS  = Q_PTR_BITS + 1;

  localparam logic [IDX_BITS-1:0] CFG_HIGH_FRAC     = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] CFG_LOW_FRAC      = IDX_BITS'(1);
  localparam logic [IDX_BITS-1:0] CFG_PEAK_MINIMUM  = IDX_BITS'(2);
  localparam logic [IDX_BITS-1:0] CFG_WINDOW_LENGTH = IDX_BITS'(3);
  localparam logic [IDX_BITS-1:0] CFG_BIT_PERIOD    = IDX_BITS'(4);

  localparam logic [CFG_BITS-1:0] RST_HIGH_FRAC     = CFG_BITS'(39322);
  localparam logic [CFG_BITS-1:0] RST_LOW_FRAC      = CFG_BITS'(26214);
  localparam logic [CFG_BITS-1:0] RST_PEAK_MINIMUM  = CFG_BITS'(1024);
  localparam logic [CFG_BITS-1:0] RST_WINDOW_LENGTH = CFG_BITS'(1024);
  localparam logic [CFG_BITS-1:0] RST_BIT_PERIOD    = CFG_BITS'(16);

  typedef enum logic [EV_BITS-1:0] {
    EV_LOCKED    = 3'd0,
    EV_NO_SIGNAL = 3'd1,
    EV_LOW_BITS  = 3'd2,
    EV_HIGH_BITS = 3'd3,
    EV_UNDEF_RUN = 3'd4
  } ev_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] high_frac;
    logic [CFG_BITS-1:0] low_frac;
    logic [CFG_BITS-1:0] peak_minimum;
    logic [CFG_BITS-1:0] window_length;
    logic [CFG_BITS-1:0] bit_period;
  } cfg_t;

  typedef struct packed {
    ev_t                 ev;
    logic [RUN_BITS-1:0] len;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/pnrls_front.sv
// ----------------------------------------------------------------------------
// pnrls_front
// peak tracking, lock window and hysteresis slicing, one sample per cycle while accept is high
// ----------------------------------------------------------------------------
module pnrls_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pnrls_pkg::cfg_t                   cfg,
  input  logic                              accept,
  input  logic [pnrls_pkg::SAMPLE_BITS-1:0] amplitude,
  output logic                              push,
  output pnrls_pkg::item_t                  item
);
  import pnrls_pkg::*;

  typedef enum logic [1:0] {
    M_ACQ       = 2'd0,
    M_SEEK_HIGH = 2'd1,
    M_SEEK_LOW  = 2'd2
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic [CFG_BITS-1:0]    wc_r, wc_nxt;
  logic [RUN_BITS-1:0]    run_r, run_nxt;

  logic [CFG_BITS-1:0]    wl;
  logic [WIN_BITS-1:0]    cnt;
  logic [SAMPLE_BITS-1:0] pk_max;
  logic [RUN_BITS-1:0]    rc_inc;
  logic [PROD_BITS-1:0]   prod_h, prod_l, scaled;
  logic                   is_high, is_low, no_sig;

  always_comb begin
    wl      = (cfg.window_length == '0) ? CFG_BITS'(1) : cfg.window_length;
    cnt     = {1'b0, wc_r} + WIN_BITS'(1);
    pk_max  = (amplitude > peak_r) ? amplitude : peak_r;
    rc_inc  = (run_r != '1) ? run_r + RUN_BITS'(1) : run_r;
    prod_h  = PROD_BITS'(cfg.high_frac) * PROD_BITS'(pk_max);
    prod_l  = PROD_BITS'(cfg.low_frac) * PROD_BITS'(pk_max);
    scaled  = {amplitude, {CFG_BITS{1'b0}}};
    is_high = prod_h < scaled;
    is_low  = prod_l > scaled;
    no_sig  = (peak_r == '0) || (PK_CMP_BITS'(cfg.peak_minimum) > PK_CMP_BITS'(peak_r));

    mode_nxt = mode_r;
    peak_nxt = peak_r;
    wc_nxt   = wc_r;
    run_nxt  = run_r;
    push     = 1'b0;
    item.ev  = EV_LOCKED;
    item.len = rc_inc;

    if (accept) begin
      case (mode_r)
        M_SEEK_HIGH: begin
          peak_nxt = pk_max;
          run_nxt  = rc_inc;
          if (is_high) begin
            mode_nxt = M_SEEK_LOW;
            run_nxt  = '0;
            push     = 1'b1;
            item.ev  = EV_LOW_BITS;
          end
        end
        M_SEEK_LOW: begin
          peak_nxt = pk_max;
          run_nxt  = rc_inc;
          if (is_low) begin
            mode_nxt = M_SEEK_HIGH;
            run_nxt  = '0;
            push     = 1'b1;
            item.ev  = EV_HIGH_BITS;
          end
        end
        default: begin
          if (cnt >= {1'b0, wl}) begin
            wc_nxt   = '0;
            push     = 1'b1;
            item.len = RUN_BITS'(cnt);
            if (no_sig) begin
              item.ev = EV_NO_SIGNAL;
            end else begin
              item.ev  = EV_LOCKED;
              mode_nxt = M_SEEK_HIGH;
              run_nxt  = '0;
            end
          end else begin
            wc_nxt   = cnt[CFG_BITS-1:0];
            peak_nxt = pk_max;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_ACQ;
      peak_r <= '0;
      wc_r   <= '0;
      run_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      peak_r <= peak_nxt;
      wc_r   <= wc_nxt;
      run_r  <= run_nxt;
    end
  end

endmodule

### rtl/pnrls_queue.sv
// ----------------------------------------------------------------------------
// pnrls_queue
// short queue of run records between front and back
// ----------------------------------------------------------------------------
module pnrls_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pnrls_pkg::item_t   wr_item,
  input  logic               pop,
  output pnrls_pkg::item_t   rd_item,
  output pnrls_pkg::q_stat_t stat
);
  import pnrls_pkg::*;

  item_t                 mem_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wp_r, rp_r;
  logic [Q_CNT_BITS-1:0] cnt_r;
  logic                  do_push, do_pop;

  assign stat.full  = (cnt_r == Q_CNT_BITS'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_item    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + Q_PTR_BITS'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + Q_PTR_BITS'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + Q_CNT_BITS'(1);
        2'b01:   cnt_r <= cnt_r - Q_CNT_BITS'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/pnrls_back.sv
// ----------------------------------------------------------------------------
// pnrls_back
// run classification, bit-serial division by the bit period, result register
// ----------------------------------------------------------------------------
module pnrls_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pnrls_pkg::cfg_t                cfg,
  input  pnrls_pkg::item_t               rd_item,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  logic                           out_pop,
  output logic                           out_empty,
  output logic [pnrls_pkg::EV_BITS-1:0]  out_event_res,
  output logic [pnrls_pkg::RUN_BITS-1:0] out_bit_count,
  output logic [pnrls_pkg::RUN_BITS-1:0] out_run_length
);
  import pnrls_pkg::*;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_DIV  = 1'b1
  } bstate_t;

  bstate_t                 state_r;
  logic                    out_valid_r;
  ev_t                     ev_r, dev_r;
  logic [RUN_BITS-1:0]     bits_r, len_r, dlen_r, quo_r;
  logic [CFG_BITS-1:0]     rem_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;

  logic [CFG_BITS-1:0]     bp_eff;
  logic [CFG_BITS:0]       rem_sh;
  logic                    ge;
  logic [RUN_BITS-1:0]     quo_nxt;
  logic [CFG_BITS-1:0]     rem_nxt;
  logic                    is_bits, long_run, out_fire;

  always_comb begin
    bp_eff   = (cfg.bit_period == '0) ? CFG_BITS'(1) : cfg.bit_period;
    rem_sh   = {rem_r, quo_r[RUN_BITS-1]};
    ge       = rem_sh >= {1'b0, bp_eff};
    quo_nxt  = {quo_r[RUN_BITS-2:0], ge};
    rem_nxt  = ge ? CFG_BITS'(rem_sh - {1'b0, bp_eff}) : rem_sh[CFG_BITS-1:0];
    is_bits  = (rd_item.ev == EV_LOW_BITS) || (rd_item.ev == EV_HIGH_BITS);
    long_run = LEN_CMP_BITS'(cfg.bit_period) < LEN_CMP_BITS'(rd_item.len);
    out_fire = out_pop && out_valid_r;
    q_pop    = (state_r == B_IDLE) && !q_empty && (!out_valid_r || out_fire);
  end

  assign out_empty      = !out_valid_r;
  assign out_event_res  = ev_r;
  assign out_bit_count  = bits_r;
  assign out_run_length = len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            if (is_bits && long_run) begin
              state_r     <= B_DIV;
              out_valid_r <= 1'b0;
              quo_r       <= rd_item.len;
              rem_r       <= '0;
              cnt_r       <= DIV_CNT_BITS'(RUN_BITS - 1);
              dev_r       <= rd_item.ev;
              dlen_r      <= rd_item.len;
            end else begin
              out_valid_r <= 1'b1;
              ev_r        <= is_bits ? EV_UNDEF_RUN : rd_item.ev;
              bits_r      <= '0;
              len_r       <= rd_item.len;
            end
          end else if (out_fire) begin
            out_valid_r <= 1'b0;
          end
        end
        B_DIV: begin
          quo_r <= quo_nxt;
          rem_r <= rem_nxt;
          if (cnt_r == '0) begin
            state_r     <= B_IDLE;
            out_valid_r <= 1'b1;
            ev_r        <= dev_r;
            bits_r      <= quo_nxt;
            len_r       <= dlen_r;
          end else begin
            cnt_r <= cnt_r - DIV_CNT_BITS'(1);
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

### rtl/peak_normalized_run_length_slicer_unit.sv
// path: a result for lock, no-signal and short runs passes the queue entry, then the output register;
//   a bit run longer than the bit period also takes 20 steps of the bit-serial divider in the back part
// throughput: one sample per cycle while in_full is low; each long bit run holds the divider and a
//   4-entry queue absorbs bursts, full rises when it is exhausted
// reset: synchronous, config and control registers return to defaults, acquiring with zero peak, queue empty
// ----------------------------------------------------------------------------
// peak_normalized_run_length_slicer_unit
// peak normalised hysteresis slicer reporting run lengths as bit counts
// ----------------------------------------------------------------------------
module peak_normalized_run_length_slicer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [pnrls_pkg::SAMPLE_BITS-1:0] in_amplitude,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [pnrls_pkg::EV_BITS-1:0]     out_event_res,
  output logic [pnrls_pkg::RUN_BITS-1:0]    out_bit_count,
  output logic [pnrls_pkg::RUN_BITS-1:0]    out_run_length,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pnrls_pkg::IDX_BITS-1:0]    cfg_index,
  input  logic [pnrls_pkg::CFG_BITS-1:0]    cfg_wdata
);
  import pnrls_pkg::*;

  cfg_t    cfg_r;
  logic    accept, push, q_pop;
  item_t   wr_item, rd_item;
  q_stat_t q_stat;

  assign cfg_ready = 1'b1;
  assign in_full   = q_stat.full;
  assign accept    = in_push && !q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_frac     <= RST_HIGH_FRAC;
      cfg_r.low_frac      <= RST_LOW_FRAC;
      cfg_r.peak_minimum  <= RST_PEAK_MINIMUM;
      cfg_r.window_length <= RST_WINDOW_LENGTH;
      cfg_r.bit_period    <= RST_BIT_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HIGH_FRAC:     cfg_r.high_frac     <= cfg_wdata;
        CFG_LOW_FRAC:      cfg_r.low_frac      <= cfg_wdata;
        CFG_PEAK_MINIMUM:  cfg_r.peak_minimum  <= cfg_wdata;
        CFG_WINDOW_LENGTH: cfg_r.window_length <= cfg_wdata;
        CFG_BIT_PERIOD:    cfg_r.bit_period    <= cfg_wdata;
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  pnrls_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .amplitude (in_amplitude),
    .push      (push),
    .item      (wr_item)
  );

  pnrls_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (q_pop),
    .rd_item (rd_item),
    .stat    (q_stat)
  );

  pnrls_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .rd_item        (rd_item),
    .q_empty        (q_stat.empty),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_event_res  (out_event_res),
    .out_bit_count  (out_bit_count),
    .out_run_length (out_run_length)
  );

endmodule
